>>> rtl/core/gfpd_pkg.sv
package gfpd_pkg;

  localparam int HALF_WINDOW_DEF = 5;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int RAW_HIST = 4;  // older raw samples kept beside the incoming one

  // 1-3-5-3-1 kernel sum of five 16-bit samples spans -425984 to +425971
  localparam int SUM_W = 20;
  localparam int MAG_W = 19;

  // x / 13 == (x * ceil(2^24 / 13)) >> 24, exact for x < 2^24 / 12
  localparam int             DIV13_SHIFT  = 24;
  localparam int             DIV13_MULT_W = 21;
  localparam logic [20:0]    DIV13_MULT   = 21'd1290556;

  localparam int           CFG_IDX_W          = 8;
  localparam logic [7:0]   CFG_PEAK_THRESHOLD = 8'd0;
  localparam logic [7:0]   CFG_FREEZE_WINDOW  = 8'd1;

  localparam logic signed [15:0] PEAK_THRESHOLD_RST = 16'sd10000;
  localparam logic [15:0]        FREEZE_WINDOW_RST  = 16'd600;
  localparam logic [15:0]        FREEZE_COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] peak_threshold;
    logic [15:0]                freeze_window_ms;
  } gfpd_cfg_t;

  typedef struct packed {
    logic                       first;
    logic                       sm_valid;
    logic signed [SAMPLE_W-1:0] sm;
    logic [TIME_W-1:0]          ts;
  } gfpd_smooth_t;

endpackage

>>> rtl/core/gfpd_smoother.sv
module gfpd_smoother (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gfpd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [gfpd_pkg::TIME_W-1:0]          in_timestamp_ms,
  output logic                                s_valid,
  input  logic                                s_ready,
  output gfpd_pkg::gfpd_smooth_t              s_data
);

  localparam int PROD_W = gfpd_pkg::MAG_W + gfpd_pkg::DIV13_MULT_W;
  localparam logic [2:0] CNT_SAT = 3'd4;

  logic signed [gfpd_pkg::SAMPLE_W-1:0] raw_r [gfpd_pkg::RAW_HIST];
  logic [2:0]                           cnt_r;

  // stage 1: kernel sum, split into sign and magnitude
  logic                                 s1_v_r;
  logic                                 s1_neg_r;
  logic [gfpd_pkg::MAG_W-1:0]           s1_mag_r;
  logic                                 s1_first_r;
  logic                                 s1_smv_r;
  logic [gfpd_pkg::TIME_W-1:0]          s1_ts_r;

  // stage 2: divided value
  logic                                 s2_v_r;
  gfpd_pkg::gfpd_smooth_t               s2_r;

  logic                                 s1_ready;
  logic                                 s2_ready;
  logic                                 in_xfer;
  logic signed [gfpd_pkg::SUM_W-1:0]    x0, x1, x2, x3, x4;
  logic signed [gfpd_pkg::SUM_W-1:0]    sum;
  logic [gfpd_pkg::MAG_W-1:0]           mag;
  logic [PROD_W-1:0]                    prod;
  logic [gfpd_pkg::SAMPLE_W-1:0]        quo;
  logic [gfpd_pkg::SAMPLE_W:0]          quo_s;
  gfpd_pkg::gfpd_smooth_t               s2_nxt;

  assign s2_ready = !s2_v_r || s_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;
  assign in_xfer  = in_valid && s1_ready;

  always_comb begin
    x0  = gfpd_pkg::SUM_W'(raw_r[0]);
    x1  = gfpd_pkg::SUM_W'(raw_r[1]);
    x2  = gfpd_pkg::SUM_W'(raw_r[2]);
    x3  = gfpd_pkg::SUM_W'(raw_r[3]);
    x4  = gfpd_pkg::SUM_W'(in_sample);
    sum = x0 + (x1 <<< 1) + x1 + (x2 <<< 2) + x2 + (x3 <<< 1) + x3 + x4;
    mag = sum[gfpd_pkg::SUM_W-1] ? gfpd_pkg::MAG_W'(-sum) : gfpd_pkg::MAG_W'(sum);
  end

  always_comb begin
    prod  = PROD_W'(s1_mag_r) * PROD_W'(gfpd_pkg::DIV13_MULT);
    quo   = prod[gfpd_pkg::DIV13_SHIFT +: gfpd_pkg::SAMPLE_W];
    quo_s = s1_neg_r ? -{1'b0, quo} : {1'b0, quo};
    s2_nxt.first    = s1_first_r;
    s2_nxt.sm_valid = s1_smv_r;
    s2_nxt.sm       = s1_smv_r ? quo_s[gfpd_pkg::SAMPLE_W-1:0] : '0;
    s2_nxt.ts       = s1_ts_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (in_xfer && cnt_r != CNT_SAT) cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < gfpd_pkg::RAW_HIST - 1; i++) raw_r[i] <= raw_r[i+1];
      raw_r[gfpd_pkg::RAW_HIST-1] <= in_sample;
      s1_neg_r   <= sum[gfpd_pkg::SUM_W-1];
      s1_mag_r   <= mag;
      s1_first_r <= (cnt_r == '0);
      s1_smv_r   <= (cnt_r == CNT_SAT);
      s1_ts_r    <= in_timestamp_ms;
    end
    if (s1_v_r && s2_ready) s2_r <= s2_nxt;
  end

  assign s_valid = s2_v_r;
  assign s_data  = s2_r;

endmodule

>>> rtl/core/gfpd_peak.sv
module gfpd_peak #(
  parameter int HALF_WINDOW = gfpd_pkg::HALF_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gfpd_pkg::gfpd_cfg_t                  cfg,
  input  logic                                 s_valid,
  output logic                                 s_ready,
  input  gfpd_pkg::gfpd_smooth_t               s_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_smoothed_valid,
  output logic signed [gfpd_pkg::SAMPLE_W-1:0] out_smoothed_value,
  output logic                                 out_peak_found,
  output logic [gfpd_pkg::TIME_W-1:0]          out_peak_time_ms,
  output logic [gfpd_pkg::TIME_W-1:0]          out_peak_interval_ms,
  output logic                                 out_freeze_found,
  output logic [15:0]                          out_freeze_count
);

  localparam int SMOOTH_DEPTH = 2 * HALF_WINDOW + 1;
  localparam int TIME_DEPTH   = HALF_WINDOW + 2;
  localparam int SCNT_W       = $clog2(SMOOTH_DEPTH + 1);
  localparam logic [SCNT_W-1:0] SCNT_FULL = SCNT_W'(SMOOTH_DEPTH - 1);

  logic signed [gfpd_pkg::SAMPLE_W-1:0] win_r [SMOOTH_DEPTH];
  logic [gfpd_pkg::TIME_W-1:0]          time_r [TIME_DEPTH];
  logic [SCNT_W-1:0]                    scnt_r;
  logic [gfpd_pkg::TIME_W-1:0]          lpt_r;
  logic [15:0]                          tot_r;

  logic                                 out_v_r;
  logic                                 smv_r;
  logic signed [gfpd_pkg::SAMPLE_W-1:0] sm_r;
  logic                                 peak_r;
  logic [gfpd_pkg::TIME_W-1:0]          ptime_r;
  logic [gfpd_pkg::TIME_W-1:0]          pint_r;
  logic                                 frz_r;

  logic                                 xfer;
  logic signed [gfpd_pkg::SAMPLE_W-1:0] win_nxt [SMOOTH_DEPTH];
  logic signed [gfpd_pkg::SAMPLE_W-1:0] center;
  logic                                 full;
  logic                                 peak_nxt;
  logic [gfpd_pkg::TIME_W-1:0]          lpt_eff;
  logic [gfpd_pkg::TIME_W-1:0]          ptime;
  logic [gfpd_pkg::TIME_W-1:0]          pint;
  logic                                 frz_nxt;
  logic [15:0]                          tot_nxt;

  assign s_ready = !out_v_r || out_ready;
  assign xfer    = s_valid && s_ready;

  always_comb begin
    for (int i = 0; i < SMOOTH_DEPTH - 1; i++) begin
      win_nxt[i] = s_data.sm_valid ? win_r[i+1] : win_r[i];
    end
    win_nxt[SMOOTH_DEPTH-1] = s_data.sm_valid ? s_data.sm : win_r[SMOOTH_DEPTH-1];
    center = win_nxt[HALF_WINDOW];
    full   = s_data.sm_valid && (scnt_r >= SCNT_FULL);

    peak_nxt = full && (center > cfg.peak_threshold);
    for (int i = 0; i < SMOOTH_DEPTH; i++) begin
      if (i != HALF_WINDOW && !(center > win_nxt[i])) peak_nxt = 1'b0;
    end

    // before the first peak the interval runs from the stream's first timestamp
    lpt_eff = s_data.first ? s_data.ts : lpt_r;
    ptime   = time_r[0];
    pint    = ptime - lpt_eff;
    frz_nxt = peak_nxt && (pint < {16'b0, cfg.freeze_window_ms});
    tot_nxt = (frz_nxt && tot_r != gfpd_pkg::FREEZE_COUNT_MAX) ? tot_r + 16'd1 : tot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      scnt_r  <= '0;
      lpt_r   <= '0;
      tot_r   <= '0;
    end else begin
      if (s_ready) out_v_r <= s_valid;
      if (xfer) begin
        if (s_data.sm_valid && scnt_r != SCNT_W'(SMOOTH_DEPTH)) scnt_r <= scnt_r + SCNT_W'(1);
        if (peak_nxt) lpt_r <= ptime;
        else if (s_data.first) lpt_r <= s_data.ts;
        tot_r <= tot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      for (int i = 0; i < SMOOTH_DEPTH; i++) win_r[i] <= win_nxt[i];
      for (int i = 0; i < TIME_DEPTH - 1; i++) time_r[i] <= time_r[i+1];
      time_r[TIME_DEPTH-1] <= s_data.ts;
      smv_r   <= s_data.sm_valid;
      sm_r    <= s_data.sm;
      peak_r  <= peak_nxt;
      ptime_r <= peak_nxt ? ptime : '0;
      pint_r  <= peak_nxt ? pint : '0;
      frz_r   <= frz_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_smoothed_valid   = smv_r;
  assign out_smoothed_value   = sm_r;
  assign out_peak_found       = peak_r;
  assign out_peak_time_ms     = ptime_r;
  assign out_peak_interval_ms = pint_r;
  assign out_freeze_found     = frz_r;
  assign out_freeze_count     = tot_r;

`ifndef ASSERT_OFF
  a_freeze_needs_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && frz_r |-> peak_r)
    else $error("freeze reported without a peak");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (tot_r == $past(tot_r)) || (tot_r == $past(tot_r) + 16'd1))
    else $error("freeze total moved by more than one");

  a_total_counts_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && frz_nxt && tot_r != gfpd_pkg::FREEZE_COUNT_MAX |=>
      tot_r == $past(tot_r) + 16'd1)
    else $error("freeze not counted");

  a_peak_updates_base: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && peak_nxt |=> lpt_r == ptime_r)
    else $error("previous peak time not updated on peak");

  a_peak_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && peak_nxt |-> scnt_r >= SCNT_FULL)
    else $error("peak tested before window filled");
`endif

endmodule

>>> rtl/core/gait_freeze_peak_detector.sv
// Smooths a stream of accelerometer samples with a 1-3-5-3-1 kernel (divided
// by 13, truncated toward zero) and flags a peak when the center of the last
// 2*HALF_WINDOW+1 smoothed values is strictly above all its neighbors and
// above peak_threshold. Each peak reports its timestamp and the interval since
// the previous peak (the first interval counts from the first timestamp after
// reset); an interval below freeze_window_ms is a freeze and bumps a saturating
// 16-bit counter. Every input transfer yields exactly one result transfer. The
// block takes one sample per clock unless out_ready stalls it, and passes it
// through a kernel-sum stage, a divide-by-13 stage on one 19x21 reciprocal
// multiply, and a peak/interval stage that feeds the output register. Smoothed
// values appear from the fifth sample, peak tests from sample 2*HALF_WINDOW+5.
// Write cfg registers (index 0 peak_threshold, index 1 freeze_window_ms; other
// indexes are ignored) only while no results are outstanding.
module gait_freeze_peak_detector #(
  parameter int HALF_WINDOW = gfpd_pkg::HALF_WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gfpd_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [gfpd_pkg::TIME_W-1:0]           in_timestamp_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_smoothed_valid,
  output logic signed [gfpd_pkg::SAMPLE_W-1:0]  out_smoothed_value,
  output logic                                  out_peak_found,
  output logic [gfpd_pkg::TIME_W-1:0]           out_peak_time_ms,
  output logic [gfpd_pkg::TIME_W-1:0]           out_peak_interval_ms,
  output logic                                  out_freeze_found,
  output logic [15:0]                           out_freeze_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gfpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                           cfg_wdata
);

  gfpd_pkg::gfpd_cfg_t    cfg_r;
  logic                   s_valid;
  logic                   s_ready;
  gfpd_pkg::gfpd_smooth_t s_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_threshold   <= gfpd_pkg::PEAK_THRESHOLD_RST;
      cfg_r.freeze_window_ms <= gfpd_pkg::FREEZE_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gfpd_pkg::CFG_PEAK_THRESHOLD: cfg_r.peak_threshold   <= cfg_wdata;
        gfpd_pkg::CFG_FREEZE_WINDOW:  cfg_r.freeze_window_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gfpd_smoother u_smoother (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_timestamp_ms (in_timestamp_ms),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_data          (s_data)
  );

  gfpd_peak #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_peak (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .s_data               (s_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_smoothed_valid   (out_smoothed_valid),
    .out_smoothed_value   (out_smoothed_value),
    .out_peak_found       (out_peak_found),
    .out_peak_time_ms     (out_peak_time_ms),
    .out_peak_interval_ms (out_peak_interval_ms),
    .out_freeze_found     (out_freeze_found),
    .out_freeze_count     (out_freeze_count)
  );

endmodule
